// ===== rtl/nps_pkg.sv =====
package nps_pkg;

	localparam int MAX_PROCS_DEF = 16;
	localparam int TIME_BITS_DEF = 16;

	// fixed field widths
	localparam int ARR_W   = 16;
	localparam int BURST_W = 16;
	localparam int PRIO_W  = 8;
	localparam int JOB_W   = 5;
	localparam int RES_W   = 20;
	localparam int TICK_W  = 21;

	typedef struct packed {
		logic clear;   // drop the current best, new pick starts
		logic cmp_en;  // an entry is on the read port this cycle
	} scan_ctl_t;

endpackage

// ===== rtl/nonpreemptive_priority_scheduler.sv =====
// Non-preemptive priority scheduler.
// Input channel (in_valid/in_stall): one job per request with arrival_time,
// burst_time, job_priority and last_job. While idle in_stall is low and a job
// is taken every cycle; jobs beyond MAX_PROCS are dropped. A request with
// last_job set closes the set and starts scheduling; in_stall stays high until
// the last result has been taken.
// Output channel (out_valid/out_stall): one result per stored job in run
// order, last_result set on the final one. Each result takes one pass over
// the job memory (one entry per cycle through the single read port and one
// shared key comparator), a drain state, then tick update, wait and
// turnaround computation.
// A result sits in the output register while out_stall is high; the next pick
// starts only after it is taken.
// Reset (arst_n low) empties the job set and the scheduled marks and returns
// the block to idle; the job memory itself is not cleared.
module nonpreemptive_priority_scheduler import nps_pkg::*; #(
	parameter int MAX_PROCS = MAX_PROCS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [ARR_W-1:0]   arrival_time,
	input  logic [BURST_W-1:0] burst_time,
	input  logic [PRIO_W-1:0]  job_priority,
	input  logic               last_job,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [JOB_W-1:0]   job_number,
	output logic [RES_W-1:0]   wait_time,
	output logic [RES_W-1:0]   turnaround_time,
	output logic               last_result
);

	localparam int SW = (TIME_BITS < ARR_W) ? TIME_BITS : ARR_W;
	localparam int IW = $clog2(MAX_PROCS);
	localparam int CW = $clog2(MAX_PROCS + 1);
	localparam int MW = SW + SW + PRIO_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_JUMP,
		ST_CALC,
		ST_DONE,
		ST_OUT
	} state_t;

	state_t                state_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         done_q;
	logic [IW-1:0]         rd_idx_q;
	logic [TICK_W-1:0]     tick_q;
	logic [MAX_PROCS-1:0]  marks_q;
	logic                  vld_s1;
	logic [IW-1:0]         idx_s1;
	logic                  mark_s1;

	logic                  accept;
	logic                  wr_en;
	logic [MW-1:0]         wr_word;
	logic [MW-1:0]         rd_word;
	scan_ctl_t             scan_ctl;
	logic                  best_found;
	logic                  best_elig;
	logic [SW-1:0]         best_arr;
	logic [SW-1:0]         best_burst;
	logic [IW-1:0]         best_idx;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign wr_en    = accept && (count_q < CW'(MAX_PROCS));
	assign wr_word  = {arrival_time[SW-1:0], burst_time[SW-1:0], job_priority};

	nps_job_ram #(
		.DEPTH (MAX_PROCS),
		.WIDTH (MW)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (count_q[IW-1:0]),
		.wdata (wr_word),
		.raddr (rd_idx_q),
		.rdata (rd_word)
	);

	assign scan_ctl.clear  = (state_q == ST_SCAN) && (rd_idx_q == '0);
	assign scan_ctl.cmp_en = vld_s1;

	nps_scan_unit #(
		.MAX_PROCS (MAX_PROCS),
		.SW        (SW)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (scan_ctl),
		.tick       (tick_q),
		.ent_arr    (rd_word[MW-1 -: SW]),
		.ent_burst  (rd_word[PRIO_W +: SW]),
		.ent_prio   (rd_word[PRIO_W-1:0]),
		.ent_idx    (idx_s1),
		.ent_mark   (mark_s1),
		.best_found (best_found),
		.best_elig  (best_elig),
		.best_arr   (best_arr),
		.best_burst (best_burst),
		.best_idx   (best_idx)
	);

	// read stage alongside the registered memory output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= rd_idx_q;
		mark_s1 <= marks_q[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			count_q         <= '0;
			done_q          <= '0;
			rd_idx_q        <= '0;
			tick_q          <= '0;
			marks_q         <= '0;
			out_valid       <= 1'b0;
			job_number      <= '0;
			wait_time       <= '0;
			turnaround_time <= '0;
			last_result     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					rd_idx_q <= '0;
					done_q   <= '0;
					tick_q   <= '0;
					if (accept) begin
						if (wr_en) begin
							count_q <= count_q + 1'b1;
						end
						if (last_job) begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (rd_idx_q == IW'(count_q - 1'b1)) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_JUMP;
				end
				ST_JUMP: begin
					// nothing has arrived: idle until the earliest pending job
					if (!best_elig) begin
						tick_q <= TICK_W'(best_arr);
					end
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					wait_time <= RES_W'(tick_q - TICK_W'(best_arr));
					tick_q    <= tick_q + TICK_W'(best_burst);
					state_q   <= ST_DONE;
				end
				ST_DONE: begin
					turnaround_time   <= RES_W'(tick_q - TICK_W'(best_arr));
					job_number        <= JOB_W'({1'b0, best_idx} + 1'b1);
					last_result       <= (done_q == CW'(count_q - 1'b1));
					marks_q[best_idx] <= 1'b1;
					out_valid         <= 1'b1;
					state_q           <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						rd_idx_q  <= '0;
						if (last_result) begin
							count_q <= '0;
							marks_q <= '0;
							tick_q  <= '0;
							state_q <= ST_IDLE;
						end else begin
							done_q  <= done_q + 1'b1;
							state_q <= ST_SCAN;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// results appear only while scheduling, never while loading
	a_no_out_when_loading: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("result shown while accepting requests");

	// closing request always starts a scheduling run
	a_last_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && last_job) |=> (in_stall && !out_valid))
		else $error("last request did not start scheduling");

	// a shown result names a stored, freshly picked job
	a_pick_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (best_found && (CW'(best_idx) < count_q) && marks_q[best_idx]))
		else $error("picked job outside the loaded set");

	// never more jobs scheduled than loaded
	a_marks_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(marks_q) <= int'(count_q))
		else $error("scheduled marks exceed job count");

endmodule

// ===== rtl/nps_job_ram.sv =====
module nps_job_ram import nps_pkg::*; #(
	parameter int DEPTH = MAX_PROCS_DEF,
	parameter int WIDTH = 40
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/nps_scan_unit.sv =====
module nps_scan_unit import nps_pkg::*; #(
	parameter int MAX_PROCS = MAX_PROCS_DEF,
	parameter int SW        = ARR_W
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  scan_ctl_t                    ctl,
	input  logic [TICK_W-1:0]            tick,
	input  logic [SW-1:0]                ent_arr,
	input  logic [SW-1:0]                ent_burst,
	input  logic [PRIO_W-1:0]            ent_prio,
	input  logic [$clog2(MAX_PROCS)-1:0] ent_idx,
	input  logic                         ent_mark,
	output logic                         best_found,
	output logic                         best_elig,
	output logic [SW-1:0]                best_arr,
	output logic [SW-1:0]                best_burst,
	output logic [$clog2(MAX_PROCS)-1:0] best_idx
);

	localparam int KW = 1 + PRIO_W + SW;

	logic          elig;
	logic [KW-1:0] key;
	logic [KW-1:0] best_key_q;
	logic          found_q;
	logic          take;

	// Arrived jobs rank first by (priority, arrival); pending ones by
	// (arrival, priority), so a pick with nothing arrived lands on the
	// job the tick would jump to. Ascending scan + strict compare keeps
	// the lower index on a full tie.
	assign elig = (TICK_W'(ent_arr) <= tick);
	assign key  = elig ? {1'b0, ent_prio, ent_arr} : {1'b1, ent_arr, ent_prio};
	assign take = ctl.cmp_en && !ent_mark && (!found_q || (key < best_key_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_key_q <= key;
			best_arr   <= ent_arr;
			best_burst <= ent_burst;
			best_idx   <= ent_idx;
		end
	end

	assign best_found = found_q;
	assign best_elig  = !best_key_q[KW-1];

endmodule
